### sv/ri2a_pkg.sv
`default_nettype none

package ri2a_pkg;

  localparam int DIGIT_W  = 4;
  localparam int DIV_STEP = 8;   // quotient bits resolved per divider cycle

  localparam logic [4:0] BASE_MIN = 5'd2;
  localparam logic [4:0] BASE_MAX = 5'd16;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_UPPER_A = 8'h41;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [63:0] value;
    logic [4:0]  base;
    logic        uppercase;
  } cmd_t;

  typedef struct packed {
    logic [7:0] digit_char;
    logic       last;
  } dig_t;

  typedef struct packed {
    logic               done;
    logic [DIGIT_W-1:0] rem;
  } div_res_t;

endpackage

`default_nettype wire

### sv/ri2a_div.sv
`default_nettype none

// Iterative radix divider, DIV_STEP quotient bits per cycle.
module ri2a_div #(
  parameter int VALUE_WIDTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [VALUE_WIDTH-1:0]   operand,
  input  wire logic [4:0]               base,
  output ri2a_pkg::div_res_t            res,
  output logic      [VALUE_WIDTH-1:0]   quot
);

  localparam int CHUNKS = (VALUE_WIDTH + ri2a_pkg::DIV_STEP - 1) / ri2a_pkg::DIV_STEP;
  localparam int PAD_W  = CHUNKS * ri2a_pkg::DIV_STEP;
  localparam int CW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

  logic                          busy;
  logic [CW-1:0]                 cnt;
  logic [PAD_W-1:0]              q_reg;
  logic [PAD_W-1:0]              q_next;
  logic [ri2a_pkg::DIGIT_W-1:0]  rem;
  logic [ri2a_pkg::DIGIT_W-1:0]  rem_next;
  logic [4:0]                    base_r;
  logic [ri2a_pkg::DIV_STEP-1:0] qbits;

  // restoring steps; remainder stays below base, so {rem,bit} fits 5 bits
  always_comb begin
    logic [ri2a_pkg::DIGIT_W-1:0] r;
    logic [4:0]                   t;
    r     = rem;
    qbits = '0;
    for (int j = 0; j < ri2a_pkg::DIV_STEP; j++) begin
      t = {r, q_reg[PAD_W-1-j]};
      if (t >= base_r) begin
        qbits[ri2a_pkg::DIV_STEP-1-j] = 1'b1;
        t = t - base_r;
      end
      r = t[ri2a_pkg::DIGIT_W-1:0];
    end
    rem_next = r;
    q_next   = (q_reg << ri2a_pkg::DIV_STEP) | PAD_W'(qbits);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (res.done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt    <= CW'(CHUNKS - 1);
      q_reg  <= PAD_W'(operand);
      rem    <= '0;
      base_r <= base;
    end else if (busy) begin
      cnt    <= cnt - CW'(1);
      q_reg  <= q_next;
      rem    <= rem_next;
    end
  end

  assign res.done = busy && (cnt == '0);
  assign res.rem  = rem_next;
  assign quot     = q_next[VALUE_WIDTH-1:0];

endmodule

`default_nettype wire

### sv/ri2a_mem.sv
`default_nettype none

// Digit store: one write port, one registered read port.
module ri2a_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [AW-1:0]                waddr,
  input  wire logic [ri2a_pkg::DIGIT_W-1:0] wdata,
  input  wire logic                         re,
  input  wire logic [AW-1:0]                raddr,
  output logic      [ri2a_pkg::DIGIT_W-1:0] rdata
);

  logic [ri2a_pkg::DIGIT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### sv/radix_integer_to_ascii_top.sv
// The single radix divider (8 quotient bits a cycle) yields the digits, least significant
//   first, into the digit store; one digit-store read follows per emitted digit.
// A request is taken only while idle, after the last digit of the one before has been read.
// A bad base is taken and gives nothing.
// Reset: synchronous, active high; clears control state, digit store is not cleared.
`default_nettype none

module radix_integer_to_ascii_top #(
  parameter int VALUE_WIDTH = 64,
  parameter int MAX_DIGITS  = 64
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  output logic                cmd_stall,
  input  wire ri2a_pkg::cmd_t cmd,
  output logic                dig_valid,
  input  wire logic           dig_stall,
  output ri2a_pkg::dig_t      dig
);

  localparam int AW    = $clog2(MAX_DIGITS);
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  // ---------------------------------------------------------------- control
  ri2a_pkg::state_t state;
  ri2a_pkg::state_t state_next;

  logic [CNT_W-1:0] n;        // digits produced so far
  logic [CNT_W-1:0] n_inc;
  logic [CNT_W-1:0] left;     // digits still to read out
  logic [CNT_W-1:0] left_m1;
  logic [4:0]       base_r;
  logic             upper_r;

  // output stage: memory read register plus these flags
  logic             out_valid;
  logic             out_last;
  logic             out_upper;

  logic             accept;
  logic             base_ok;
  logic             more;
  logic             issue;

  // divider interface
  logic                         div_start;
  logic [VALUE_WIDTH-1:0]       div_operand;
  logic [4:0]                   div_base;
  ri2a_pkg::div_res_t           div_res;
  logic [VALUE_WIDTH-1:0]       div_quot;

  // digit store interface
  logic                         mem_we;
  logic [ri2a_pkg::DIGIT_W-1:0] mem_rdata;

  assign accept  = cmd_valid && !cmd_stall;
  assign base_ok = (cmd.base >= ri2a_pkg::BASE_MIN) && (cmd.base <= ri2a_pkg::BASE_MAX);
  assign n_inc   = n + CNT_W'(1);
  assign left_m1 = left - CNT_W'(1);

  // keep dividing while the quotient is nonzero and the store has room
  assign more  = (div_quot != '0) && (n_inc < CNT_W'(MAX_DIGITS));

  // read the next digit only when the output stage frees up this cycle
  assign issue = (state == ri2a_pkg::S_EMIT) && (left != '0) && (!out_valid || !dig_stall);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ri2a_pkg::S_IDLE: begin
        if (accept && base_ok) state_next = ri2a_pkg::S_DIV;
      end
      ri2a_pkg::S_DIV: begin
        if (div_res.done && !more) state_next = ri2a_pkg::S_EMIT;
      end
      ri2a_pkg::S_EMIT: begin
        if (left == '0) state_next = ri2a_pkg::S_IDLE;
      end
      default: state_next = ri2a_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    div_start   = 1'b0;
    div_operand = '0;
    div_base    = base_r;
    mem_we      = 1'b0;
    unique case (state)
      ri2a_pkg::S_IDLE: begin
        div_base = cmd.base;
        if (accept && base_ok) begin
          div_start   = 1'b1;
          div_operand = cmd.value[VALUE_WIDTH-1:0];
        end
      end
      ri2a_pkg::S_DIV: begin
        if (div_res.done) begin
          mem_we = 1'b1;
          if (more) begin
            div_start   = 1'b1;
            div_operand = div_quot;
          end
        end
      end
      ri2a_pkg::S_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ri2a_pkg::S_IDLE;
      out_valid <= 1'b0;
      n         <= '0;
      left      <= '0;
    end else begin
      state <= state_next;

      if (issue) begin
        out_valid <= 1'b1;
      end else if (!dig_stall) begin
        out_valid <= 1'b0;
      end

      if (accept && base_ok) begin
        n <= '0;
      end else if ((state == ri2a_pkg::S_DIV) && div_res.done) begin
        n <= n_inc;
      end

      if ((state == ri2a_pkg::S_DIV) && div_res.done && !more) begin
        left <= n_inc;
      end else if (issue) begin
        left <= left_m1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      base_r  <= cmd.base;
      upper_r <= cmd.uppercase;
    end
    // letter case travels with the digit; a new request may change upper_r
    if (issue) begin
      out_last  <= (left == CNT_W'(1));
      out_upper <= upper_r;
    end
  end

  // ---------------------------------------------------------------- datapath
  ri2a_div #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .operand (div_operand),
    .base    (div_base),
    .res     (div_res),
    .quot    (div_quot)
  );

  // remainders land least significant first; read back from the top down
  ri2a_mem #(
    .DEPTH (MAX_DIGITS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (n[AW-1:0]),
    .wdata (div_res.rem),
    .re    (issue),
    .raddr (left_m1[AW-1:0]),
    .rdata (mem_rdata)
  );

  function automatic logic [7:0] to_ascii(input logic [ri2a_pkg::DIGIT_W-1:0] d,
                                          input logic up);
    logic [7:0] d8;
    d8 = {4'b0000, d};
    if (d < 4'd10) begin
      return ri2a_pkg::CH_ZERO + d8;
    end
    return (up ? ri2a_pkg::CH_UPPER_A : ri2a_pkg::CH_LOWER_A) + d8 - 8'd10;
  endfunction

  assign cmd_stall      = (state != ri2a_pkg::S_IDLE);
  assign dig_valid      = out_valid;
  assign dig.digit_char = to_ascii(mem_rdata, out_upper);
  assign dig.last       = out_last;

endmodule

`default_nettype wire

### sv/ri2a_chk.sv
`default_nettype none

module ri2a_chk (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           cmd_valid,
  input wire logic           cmd_stall,
  input wire ri2a_pkg::cmd_t cmd,
  input wire logic           dig_valid,
  input wire logic           dig_stall,
  input wire ri2a_pkg::dig_t dig
);

  // stalled digit holds
  a_dig_hold: assert property (@(posedge clk) disable iff (rst)
    dig_valid && dig_stall |=> dig_valid && $stable(dig))
    else $error("digit changed under stall");

  // a request with a usable base keeps the block busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall && (cmd.base >= 5'd2) && (cmd.base <= 5'd16) |=> cmd_stall)
    else $error("request with valid base did not start a conversion");

  // only hex digit characters come out
  a_charset: assert property (@(posedge clk) disable iff (rst)
    dig_valid |-> ((dig.digit_char >= 8'h30) && (dig.digit_char <= 8'h39)) ||
                  ((dig.digit_char >= 8'h41) && (dig.digit_char <= 8'h46)) ||
                  ((dig.digit_char >= 8'h61) && (dig.digit_char <= 8'h66)))
    else $error("digit character out of range");

  // block frees up only right after the final digit was presented
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    $fell(cmd_stall) |-> $past(dig_valid && dig.last))
    else $error("ready again without a final digit");

endmodule

bind radix_integer_to_ascii_top ri2a_chk u_ri2a_chk (.*);

`default_nettype wire

### sim/ri2a_digit_checker.sv
module ri2a_digit_checker #(
  parameter int VALUE_WIDTH = 64,
  parameter int MAX_DIGITS  = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  logic              cmd_stall,
  input  ri2a_pkg::cmd_t    cmd,
  input  logic              dig_valid,
  input  logic              dig_stall,
  input  ri2a_pkg::dig_t    dig,
  output int                mismatches,
  output int                outstanding
);

  localparam logic [63:0] VALUE_MASK =
    (VALUE_WIDTH >= 64) ? '1 : ((64'd1 << VALUE_WIDTH) - 64'd1);

  // digits still owed by the block, most significant first per request
  ri2a_pkg::dig_t expected_digits[$];

  // Repeated division by the radix; remainders come out least significant first.
  function automatic void queue_expected_digits(input ri2a_pkg::cmd_t req);
    logic [63:0]    quot;
    logic [63:0]    radix;
    logic [3:0]     rems [64];
    int             n;
    int             k;
    ri2a_pkg::dig_t d;
    if (req.base < ri2a_pkg::BASE_MIN || req.base > ri2a_pkg::BASE_MAX) return;
    quot  = req.value & VALUE_MASK;
    radix = {59'd0, req.base};
    n     = 0;
    if (quot == 64'd0) begin
      rems[0] = 4'd0;
      n = 1;
    end else begin
      while (quot != 64'd0 && n < MAX_DIGITS) begin
        rems[n] = 4'(quot % radix);
        quot    = quot / radix;
        n++;
      end
    end
    for (k = n - 1; k >= 0; k--) begin
      if (rems[k] < 4'd10)
        d.digit_char = ri2a_pkg::CH_ZERO + {4'd0, rems[k]};
      else
        d.digit_char = (req.uppercase ? ri2a_pkg::CH_UPPER_A : ri2a_pkg::CH_LOWER_A) +
                       {4'd0, rems[k]} - 8'd10;
      d.last = (k == 0);
      expected_digits.push_back(d);
    end
  endfunction

  always @(posedge clk) begin
    ri2a_pkg::dig_t want;
    if (rst) begin
      mismatches  = 0;
      outstanding = 0;
    end else begin
      if (cmd_valid && !cmd_stall) queue_expected_digits(cmd);
      if (dig_valid && !dig_stall) begin
        if (expected_digits.size() == 0) begin
          $error("digit with no request pending: digit_char 0x%02h last %0b",
                 dig.digit_char, dig.last);
          mismatches++;
        end else begin
          want = expected_digits.pop_front();
          if (dig.digit_char !== want.digit_char) begin
            $error("digit_char: expected 0x%02h, actual 0x%02h",
                   want.digit_char, dig.digit_char);
            mismatches++;
          end
          if (dig.last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, dig.last);
            mismatches++;
          end
        end
      end
      outstanding = expected_digits.size();
    end
  end

endmodule

### sim/radix_integer_to_ascii_top_test.sv
// Stimulus and verdict for the radix converter. All prediction and
// comparison sits in ri2a_digit_checker; this module only drives the two
// channels and decides pass/fail from the checker's counters.
module radix_integer_to_ascii_top_test;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic           cmd_valid;
  logic           cmd_stall;
  ri2a_pkg::cmd_t cmd;
  logic           dig_valid;
  logic           dig_stall;
  ri2a_pkg::dig_t dig;

  int mismatches;
  int outstanding;

  // set by the stimulus loop to run stretches of back-to-back requests
  bit no_gap_run = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  radix_integer_to_ascii_top uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .dig_valid (dig_valid),
    .dig_stall (dig_stall),
    .dig       (dig)
  );

  ri2a_digit_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .cmd         (cmd),
    .dig_valid   (dig_valid),
    .dig_stall   (dig_stall),
    .dig         (dig),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  function automatic ri2a_pkg::cmd_t make_req(input logic [63:0] v, input logic [4:0] b,
                                              input logic u);
    ri2a_pkg::cmd_t r;
    r.value     = v;
    r.base      = b;
    r.uppercase = u;
    return r;
  endfunction

  // Offer one request and return at the edge where it is taken.
  // Valid only drops when a gap follows, so back-to-back requests never
  // see valid lowered and raised in the same step.
  task automatic offer_request(input ri2a_pkg::cmd_t req);
    int gap;
    gap = no_gap_run ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd       <= req;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
  endtask

  // Digit sink. Draws a stall per digit, with stretches of no stall at all,
  // and once holds off for a long while so the block backs up and the
  // request side sees cmd_stall for many cycles.
  initial begin : digit_sink
    int hold;
    int taken;
    taken = 0;
    dig_stall <= 1'b1;
    while (rst) @(posedge clk);
    forever begin
      if (taken == 600)
        hold = 1500;
      else if ((taken / 150) % 3 == 1)
        hold = 0;
      else
        hold = $urandom_range(0, 18);
      if (hold > 0) begin
        dig_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      dig_stall <= 1'b0;
      do @(posedge clk); while (!dig_valid);
      taken++;
    end
  end

  initial begin : stimulus
    int          sent;
    int          bits;
    logic [63:0] v;
    logic [4:0]  b;
    cmd_valid <= 1'b0;
    cmd       <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero value: always a single '0'
    offer_request(make_req(64'd0, 5'd10, 1'b0));
    offer_request(make_req(64'd0, 5'd2, 1'b1));
    offer_request(make_req(64'd0, 5'd16, 1'b1));
    // full-scale value: 64 binary digits is the digit-store limit
    offer_request(make_req('1, 5'd2, 1'b0));
    offer_request(make_req('1, 5'd16, 1'b0));
    offer_request(make_req('1, 5'd16, 1'b1));
    offer_request(make_req('1, 5'd10, 1'b1));
    offer_request(make_req('1, 5'd3, 1'b0));
    // every hex letter in both cases
    offer_request(make_req(64'hFEDC_BA98_7654_3210, 5'd16, 1'b1));
    offer_request(make_req(64'h0123_4567_89AB_CDEF, 5'd16, 1'b0));
    offer_request(make_req(64'd10, 5'd11, 1'b0));
    offer_request(make_req(64'd255, 5'd15, 1'b1));
    // bad radix: taken, nothing comes out
    offer_request(make_req(64'd1234, 5'd0, 1'b0));
    offer_request(make_req(64'd1234, 5'd1, 1'b1));
    offer_request(make_req(64'd1234, 5'd17, 1'b0));
    offer_request(make_req('1, 5'd31, 1'b1));
    // remaining radixes
    offer_request(make_req(64'd1, 5'd4, 1'b0));
    offer_request(make_req(64'hDEAD_BEEF, 5'd5, 1'b1));
    offer_request(make_req(64'd123_456_789, 5'd6, 1'b0));
    offer_request(make_req(64'hFFFF_FFFF, 5'd7, 1'b1));
    offer_request(make_req(64'o1234567, 5'd8, 1'b0));
    offer_request(make_req(64'd999_999, 5'd9, 1'b1));
    offer_request(make_req(64'h8000_0000_0000_0000, 5'd12, 1'b1));
    offer_request(make_req(64'd28_560, 5'd13, 1'b0));
    offer_request(make_req(64'h0ACE_1357_9BDF_2468, 5'd14, 1'b1));

    // Random part: value length is drawn first, uniformly, so that short conversions
    // are common and the occasional full-width value still shows up.
    // About one request in ten carries an arbitrary 5-bit base.
    sent = 0;
    while (sent < 425) begin
      no_gap_run = ((sent / 40) % 3 == 2);
      bits = $urandom_range(0, 64);
      v    = {$urandom(), $urandom()};
      if (bits < 64) v = v & ((64'd1 << bits) - 64'd1);
      if ($urandom_range(0, 9) == 0)
        b = 5'($urandom_range(0, 31));
      else
        b = 5'($urandom_range(2, 16));
      offer_request(make_req(v, b, 1'($urandom_range(0, 1))));
      sent++;
    end
    cmd_valid <= 1'b0;

    // drain: let the checker see the last request, then wait out the digits
    // and a full worst-case conversion for anything stray
    repeat (2) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (600) @(posedge clk);

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin : watchdog
    #40_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
